### sv/cle_pkg.sv
// Package with shared codes, types and defaults of the cursor line editor.
`timescale 1ns / 1ps

package cle_pkg;

  localparam int CLE_CAPACITY = 1024;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_LEFT   = 3'd1,
    KIND_RIGHT  = 3'd2,
    KIND_BACK   = 3'd3,
    KIND_READ   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_BOUNDARY = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_RANGE    = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_COMMIT = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic complete;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic out_valid;
  } dp_stat_t;

endpackage

### sv/cle_ctrl.sv
// Controller state machine that sequences one operation at a time.
`timescale 1ns / 1ps

module cle_ctrl import cle_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !stat.out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.complete = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_COMMIT: begin
        // The commit waits until the output register can take the result.
        cmd.complete = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### sv/cle_dp.sv
// Datapath: the two character stacks, their counts and the result register.
`timescale 1ns / 1ps

module cle_dp import cle_pkg::*; #(
  parameter int CAPACITY = CLE_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [2:0]  kind,
  input  logic [7:0]  new_char,
  input  logic [9:0]  read_index,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [7:0]  read_char,
  output logic [10:0] text_length,
  output logic [10:0] cursor_pos,
  output logic [1:0]  status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > 10) ? CW : 10) + 1;

  logic [7:0] left_mem  [CAPACITY];
  logic [7:0] right_mem [CAPACITY];
  logic [7:0] left_rdata;
  logic [7:0] right_rdata;

  logic [CW-1:0] lc;
  logic [CW-1:0] rc;
  logic [CW-1:0] lc_next;
  logic [CW-1:0] rc_next;

  logic [2:0] item_kind;
  logic [7:0] item_char;
  logic [9:0] item_idx;

  logic [XW-1:0] lc_x;
  logic [XW-1:0] rc_x;
  logic [XW-1:0] total_x;
  logic [XW-1:0] cap_x;
  logic [XW-1:0] in_idx_x;
  logic [XW-1:0] item_idx_x;
  logic [XW-1:0] lc_m1;
  logic [XW-1:0] rc_m1;
  logic [XW-1:0] rpos;
  logic [XW-1:0] total_next;
  logic [XW-1:0] lc_next_x;

  logic [AW-1:0] left_raddr;
  logic [AW-1:0] right_raddr;
  logic          left_we;
  logic          right_we;
  logic [7:0]    left_wdata;
  logic [7:0]    rchar_n;
  status_t       status_n;
  logic          out_valid_next;

  assign lc_x       = (XW)'(lc);
  assign rc_x       = (XW)'(rc);
  assign total_x    = lc_x + rc_x;
  assign cap_x      = (XW)'(CAPACITY);
  assign in_idx_x   = (XW)'(read_index);
  assign item_idx_x = (XW)'(item_idx);
  assign lc_m1      = lc_x - 1'b1;
  assign rc_m1      = rc_x - 1'b1;
  // The right stack holds text in reverse: its top is just right of the cursor.
  assign rpos       = rc_m1 - in_idx_x + lc_x;

  // Read addresses come straight from the incoming transaction so that the
  // stack data is ready in the commit cycle.
  assign left_raddr  = (kind == KIND_READ) ? in_idx_x[AW-1:0] : lc_m1[AW-1:0];
  assign right_raddr = (kind == KIND_READ) ? rpos[AW-1:0] : rc_m1[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_kind   <= kind;
      item_char   <= new_char;
      item_idx    <= read_index;
      left_rdata  <= left_mem[left_raddr];
      right_rdata <= right_mem[right_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.complete && left_we) begin
      left_mem[lc[AW-1:0]] <= left_wdata;
    end
    if (cmd.complete && right_we) begin
      right_mem[rc[AW-1:0]] <= left_rdata;
    end
  end

  always_comb begin
    status_n   = STAT_DONE;
    rchar_n    = 8'd0;
    lc_next    = lc;
    rc_next    = rc;
    left_we    = 1'b0;
    right_we   = 1'b0;
    left_wdata = item_char;
    case (item_kind)
      KIND_INSERT: begin
        if (total_x >= cap_x || lc_x >= cap_x) begin
          status_n = STAT_FULL;
        end else begin
          left_we = 1'b1;
          lc_next = lc + 1'b1;
        end
      end
      KIND_LEFT: begin
        if (lc_x == '0 || rc_x >= cap_x) begin
          status_n = STAT_BOUNDARY;
        end else begin
          right_we = 1'b1;
          lc_next  = lc - 1'b1;
          rc_next  = rc + 1'b1;
        end
      end
      KIND_RIGHT: begin
        if (rc_x == '0 || lc_x >= cap_x) begin
          status_n = STAT_BOUNDARY;
        end else begin
          left_we    = 1'b1;
          left_wdata = right_rdata;
          lc_next    = lc + 1'b1;
          rc_next    = rc - 1'b1;
        end
      end
      KIND_BACK: begin
        if (lc_x == '0) begin
          status_n = STAT_BOUNDARY;
        end else begin
          lc_next = lc - 1'b1;
        end
      end
      KIND_READ: begin
        if (item_idx_x < lc_x) begin
          rchar_n = left_rdata;
        end else if (item_idx_x < total_x) begin
          rchar_n = right_rdata;
        end else begin
          status_n = STAT_RANGE;
        end
      end
      default: status_n = STAT_BOUNDARY;
    endcase
  end

  assign lc_next_x  = (XW)'(lc_next);
  assign total_next = lc_next_x + (XW)'(rc_next);

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.complete) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lc        <= '0;
      rc        <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (cmd.complete) begin
        lc <= lc_next;
        rc <= rc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.complete) begin
      read_char   <= rchar_n;
      text_length <= total_next[10:0];
      cursor_pos  <= lc_next_x[10:0];
      status      <= status_n;
    end
  end

  assign stat.out_valid = out_valid;

endmodule

### sv/cursor_line_editor_top.sv
// Top level of the cursor line editor: a gap buffer kept in two stacks.
// Usage:
//   The input channel (in_valid/in_ready) carries one operation per
//   transaction: kind, new_char and read_index. The output channel
//   (out_valid/out_ready) returns exactly one result per operation:
//   read_char, text_length, cursor_pos and status.
//   An operation has an accept cycle and a commit: the accept cycle launches the registered
//   read of both stacks; the commit, once the output register is free,
//   writes the stack and the counts and loads the result register. in_ready
//   is high again in the cycle after the commit, so the block takes no new
//   operation before the current one has committed. out_valid rises when
//   the commit loads the result register.
//   If the receiver holds out_ready low with a result still waiting, the
//   commit of the following operation waits, and in_ready stays low.
//   Reset (rst, synchronous) empties the text and clears out_valid;
//   the stack contents are not cleared, since no entry is read before it
//   has been written.
`timescale 1ns / 1ps

module cursor_line_editor_top import cle_pkg::*; #(
  parameter int CAPACITY = CLE_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [7:0]  new_char,
  input  logic [9:0]  read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_char,
  output logic [10:0] text_length,
  output logic [10:0] cursor_pos,
  output logic [1:0]  status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cle_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .kind        (kind),
    .new_char    (new_char),
    .read_index  (read_index),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .read_char   (read_char),
    .text_length (text_length),
    .cursor_pos  (cursor_pos),
    .status      (status)
  );

  // Only one operation is in flight: an accepted transaction blocks the next.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while one is in flight");

  // Only a successful read returns a character.
  a_char_only_on_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_DONE |-> read_char == 8'd0)
    else $error("nonzero read_char with a failing status");

  // The cursor never lies beyond the end of the text.
  a_cursor_in_text: assert property (@(posedge clk) disable iff (rst)
    out_valid && (CAPACITY < 2048) |-> cursor_pos <= text_length)
    else $error("cursor_pos beyond text_length");

  // The text never grows past the capacity.
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && (CAPACITY < 2048) |-> text_length <= CAPACITY)
    else $error("text_length beyond capacity");

endmodule

### tb/cursor_line_editor_top_tb.sv
// Testbench for the cursor line editor: directed table plus random edit sessions vs a predictor.
`timescale 1ns / 1ps

module cursor_line_editor_top_tb;
  import cle_pkg::*;

  localparam int CAP         = CLE_CAPACITY;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_MIX       = 100;
  localparam int N_FULL      = 60;
  localparam int N_DRAIN     = 120;

  // Kind codes that the block treats as no operation.
  localparam logic [2:0] KIND_SPARE_A = 3'd5;
  localparam logic [2:0] KIND_SPARE_B = 3'd6;
  localparam logic [2:0] KIND_SPARE_C = 3'd7;

  typedef enum int {
    MODE_MIX,
    MODE_FILL,
    MODE_FULL,
    MODE_DRAIN,
    MODE_DONE
  } session_mode_t;

  typedef struct packed {
    logic [7:0]  rchar;
    logic [10:0] len;
    logic [10:0] cur;
    logic [1:0]  st;
  } edit_result_t;

  typedef struct packed {
    logic [2:0]   k;
    logic [7:0]   ch;
    logic [9:0]   idx;
    logic         typed;
    edit_result_t res;
  } edit_row_t;

  localparam int N_ROWS = 22;
  localparam edit_row_t EDIT_ROWS [N_ROWS] = '{
    '{KIND_LEFT,    8'h00, 10'd0,    1'b1, '{8'h00, 11'd0, 11'd0, STAT_BOUNDARY}},
    '{KIND_RIGHT,   8'h00, 10'd0,    1'b1, '{8'h00, 11'd0, 11'd0, STAT_BOUNDARY}},
    '{KIND_BACK,    8'h00, 10'd0,    1'b1, '{8'h00, 11'd0, 11'd0, STAT_BOUNDARY}},
    '{KIND_READ,    8'h00, 10'd0,    1'b1, '{8'h00, 11'd0, 11'd0, STAT_RANGE}},
    '{KIND_READ,    8'hFF, 10'd1023, 1'b1, '{8'h00, 11'd0, 11'd0, STAT_RANGE}},
    '{KIND_SPARE_A, 8'hFF, 10'd1023, 1'b1, '{8'h00, 11'd0, 11'd0, STAT_BOUNDARY}},
    '{KIND_INSERT,  8'h00, 10'd0,    1'b1, '{8'h00, 11'd1, 11'd1, STAT_DONE}},
    '{KIND_INSERT,  8'hFF, 10'd1023, 1'b1, '{8'h00, 11'd2, 11'd2, STAT_DONE}},
    '{KIND_INSERT,  "P",   10'd0,    1'b0, '0},
    '{KIND_INSERT,  "L",   10'd0,    1'b0, '0},
    '{KIND_INSERT,  "D",   10'd0,    1'b0, '0},
    '{KIND_LEFT,    8'h00, 10'd0,    1'b0, '0},
    '{KIND_LEFT,    8'h00, 10'd0,    1'b0, '0},
    '{KIND_READ,    8'h00, 10'd0,    1'b0, '0},
    '{KIND_READ,    8'h00, 10'd1,    1'b0, '0},
    '{KIND_READ,    8'h00, 10'd4,    1'b0, '0},
    '{KIND_RIGHT,   8'h00, 10'd0,    1'b0, '0},
    '{KIND_BACK,    8'h00, 10'd0,    1'b0, '0},
    '{KIND_INSERT,  "A",   10'd0,    1'b0, '0},
    '{KIND_SPARE_B, 8'h5A, 10'd2,    1'b0, '0},
    '{KIND_SPARE_C, 8'hA5, 10'd3,    1'b0, '0},
    '{KIND_READ,    8'h00, 10'd1023, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  kind = KIND_INSERT;
  logic [7:0]  new_char = 8'h00;
  logic [9:0]  read_index = 10'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  read_char;
  logic [10:0] text_length;
  logic [10:0] cursor_pos;
  logic [1:0]  status;

  // Shadow copy of the gap buffer.
  logic [7:0] left_chars  [CAP];
  logic [7:0] right_chars [CAP];
  int         left_cnt  = 0;
  int         right_cnt = 0;

  edit_result_t  pending_results [$];
  int            error_count = 0;
  int            cycle_count = 0;
  int            burst_left  = 0;
  session_mode_t mode = MODE_MIX;
  int            mode_items = 0;
  int            row;
  int            pick;
  int            total;
  logic [2:0]    r_kind;
  logic [7:0]    r_char;
  logic [9:0]    r_idx;

  cursor_line_editor_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .new_char    (new_char),
    .read_index  (read_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_char   (read_char),
    .text_length (text_length),
    .cursor_pos  (cursor_pos),
    .status      (status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Applies one edit to the shadow buffer and returns the result it should produce.
  function automatic edit_result_t apply_edit(logic [2:0] k, logic [7:0] ch, logic [9:0] idx);
    edit_result_t r;
    int           sum;
    int           pos;
    r   = '0;
    r.st = STAT_DONE;
    sum = left_cnt + right_cnt;
    case (k)
      KIND_INSERT: begin
        if (sum >= CAP || left_cnt >= CAP) begin
          r.st = STAT_FULL;
        end else begin
          left_chars[left_cnt] = ch;
          left_cnt++;
        end
      end
      KIND_LEFT: begin
        if (left_cnt == 0 || right_cnt >= CAP) begin
          r.st = STAT_BOUNDARY;
        end else begin
          left_cnt--;
          right_chars[right_cnt] = left_chars[left_cnt];
          right_cnt++;
        end
      end
      KIND_RIGHT: begin
        if (right_cnt == 0 || left_cnt >= CAP) begin
          r.st = STAT_BOUNDARY;
        end else begin
          right_cnt--;
          left_chars[left_cnt] = right_chars[right_cnt];
          left_cnt++;
        end
      end
      KIND_BACK: begin
        if (left_cnt == 0) begin
          r.st = STAT_BOUNDARY;
        end else begin
          left_cnt--;
        end
      end
      KIND_READ: begin
        if (int'(idx) < left_cnt) begin
          r.rchar = left_chars[idx];
        end else if (int'(idx) < sum) begin
          // The right stack is stored top-down from the cursor.
          pos = right_cnt - 1 - (int'(idx) - left_cnt);
          r.rchar = right_chars[pos];
        end else begin
          r.st = STAT_RANGE;
        end
      end
      default: begin
        r.st = STAT_BOUNDARY;
      end
    endcase
    r.len = 11'(left_cnt + right_cnt);
    r.cur = 11'(left_cnt);
    return r;
  endfunction

  // Presents one operation, holds it until the transaction, then records the expectation.
  task automatic send_op(input logic [2:0] k, input logic [7:0] ch, input logic [9:0] idx,
                         input logic typed, input edit_result_t typed_res);
    edit_result_t r;
    kind       <= k;
    new_char   <= ch;
    read_index <= idx;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
    r = apply_edit(k, ch, idx);
    if (typed) begin
      r = typed_res;
    end
    pending_results = {pending_results, r};
  endtask

  // Counts down the burst; at its end, starts a new burst, mostly after a random gap; valid stays high within a burst.
  task automatic sender_gap();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = 40;
        gap = 0;
      end else begin
        burst_left = $urandom_range(0, 20);
        gap = $urandom_range(1, 6);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver stall pattern: one of four styles, redrawn at random periodically.
  int rx_style = 0;
  always @(posedge clk) begin
    if (cycle_count % 100 == 0) begin
      rx_style <= $urandom_range(0, 3);
    end
    case (rx_style)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (cycle_count % 4 == 0);
      default: out_ready <= (cycle_count % 16 >= 10);
    endcase
  end

  always @(posedge clk) begin
    edit_result_t exp_r;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no transaction pending: char %h len %0d cur %0d st %0d",
                 $time, read_char, text_length, cursor_pos, status);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (read_char !== exp_r.rchar) begin
          $display("%0t: read_char expected %h actual %h", $time, exp_r.rchar, read_char);
          error_count++;
        end
        if (text_length !== exp_r.len) begin
          $display("%0t: text_length expected %0d actual %0d", $time, exp_r.len, text_length);
          error_count++;
        end
        if (cursor_pos !== exp_r.cur) begin
          $display("%0t: cursor_pos expected %0d actual %0d", $time, exp_r.cur, cursor_pos);
          error_count++;
        end
        if (status !== exp_r.st) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.st, status);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (row = 0; row < N_ROWS; row++) begin
      send_op(EDIT_ROWS[row].k, EDIT_ROWS[row].ch, EDIT_ROWS[row].idx,
              EDIT_ROWS[row].typed, EDIT_ROWS[row].res);
      sender_gap();
    end
    wait_all_results();

    // Random edit session: mixed edits, fill to capacity, work at full, then drain.
    while (mode != MODE_DONE) begin
      total = left_cnt + right_cnt;
      pick  = $urandom_range(0, 99);
      r_char = 8'($urandom_range(0, 255));
      r_kind = KIND_READ;
      case (mode)
        MODE_MIX: begin
          if (pick < 35) r_kind = KIND_INSERT;
          else if (pick < 50) r_kind = KIND_LEFT;
          else if (pick < 65) r_kind = KIND_RIGHT;
          else if (pick < 77) r_kind = KIND_BACK;
          else if (pick < 95) r_kind = KIND_READ;
          else r_kind = 3'($urandom_range(KIND_SPARE_A, KIND_SPARE_C));
        end
        MODE_FILL: begin
          if (pick < 94) r_kind = KIND_INSERT;
          else if (pick < 96) r_kind = KIND_LEFT;
          else if (pick < 98) r_kind = KIND_RIGHT;
          else r_kind = KIND_READ;
        end
        MODE_FULL: begin
          if (pick < 30) r_kind = KIND_INSERT;
          else if (pick < 50) r_kind = KIND_LEFT;
          else if (pick < 60) r_kind = KIND_RIGHT;
          else if (pick < 95) r_kind = KIND_READ;
          else r_kind = 3'($urandom_range(KIND_SPARE_A, KIND_SPARE_C));
        end
        default: begin
          if (pick < 55) r_kind = KIND_BACK;
          else if (pick < 70) r_kind = KIND_LEFT;
          else if (pick < 80) r_kind = KIND_RIGHT;
          else if (pick < 95) r_kind = KIND_READ;
          else r_kind = KIND_INSERT;
        end
      endcase
      pick = $urandom_range(0, 99);
      if (total > 0 && pick < 70) r_idx = 10'($urandom_range(0, total - 1));
      else if (pick < 78) r_idx = 10'(total);
      else if (total > 0 && pick < 85) r_idx = 10'(total - 1);
      else r_idx = 10'($urandom_range(0, 1023));

      send_op(r_kind, r_char, r_idx, 1'b0, '0);
      sender_gap();
      mode_items++;

      case (mode)
        MODE_MIX: begin
          if (mode_items >= N_MIX) begin
            mode = MODE_FILL;
            mode_items = 0;
          end
        end
        MODE_FILL: begin
          if (left_cnt + right_cnt >= CAP) begin
            // Let the block drain completely once the buffer is full.
            wait_all_results();
            mode = MODE_FULL;
            mode_items = 0;
          end
        end
        MODE_FULL: begin
          if (mode_items >= N_FULL) begin
            mode = MODE_DRAIN;
            mode_items = 0;
          end
        end
        default: begin
          if (mode_items >= N_DRAIN) mode = MODE_DONE;
        end
      endcase
    end

    wait_all_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
